// ===== hdl/pct_pkg.sv =====
// Shared types and constants for the periodic compare timer.
`timescale 1ns / 1ps

package pct_pkg;

    localparam int CHANNELS       = 7;
    localparam int COUNT_WIDTH    = 16;
    localparam int CHAN_IDX_WIDTH = 3;
    localparam int PRESCALE_WIDTH = 6;
    localparam int DIVISOR_WIDTH  = PRESCALE_WIDTH + 1;
    localparam int LOG2_WIDTH     = 2;
    localparam int EXP_WIDTH      = 3;
    localparam int CFG_IDX_WIDTH  = 1;
    localparam int CFG_DATA_WIDTH = 3;

    typedef logic [COUNT_WIDTH-1:0]    count_t;
    typedef logic [CHANNELS-1:0]       chan_mask_t;
    typedef logic [CHAN_IDX_WIDTH-1:0] chan_idx_t;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_SET      = 2'd1,
        MODE_ACTIVATE = 2'd2,
        MODE_UNUSED   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_INPUT_DIVIDER_LOG2 = 1'b0,
        REG_EXPANSION_DIVIDER  = 1'b1
    } cfg_reg_t;

    // Command from the counter logic to the compare channels for one item.
    typedef struct packed {
        logic      step;
        logic      set;
        logic      activate;
        chan_idx_t channel;
        count_t    period;
        count_t    base_count;
        count_t    next_count;
    } chan_cmd_t;

endpackage

// ===== hdl/pct_channels.sv =====
// Compare channels: per-channel period, compare value and enable.
`timescale 1ns / 1ps

module pct_channels (
    input  logic               clk,
    input  logic               rst_n,
    input  pct_pkg::chan_cmd_t cmd,
    output pct_pkg::chan_mask_t fire
);
    import pct_pkg::*;

    count_t     compare_reg [CHANNELS];
    count_t     period_reg  [CHANNELS];
    chan_mask_t enable_reg;
    count_t     compare_next [CHANNELS];
    count_t     period_next  [CHANNELS];
    chan_mask_t enable_next;
    chan_mask_t hit;

    always_comb
    begin
        enable_next = enable_reg;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            hit[ch]          = cmd.step && enable_reg[ch] && (compare_reg[ch] == cmd.next_count);
            compare_next[ch] = compare_reg[ch];
            period_next[ch]  = period_reg[ch];
            if (hit[ch])
            begin
                compare_next[ch] = compare_reg[ch] + period_reg[ch];
            end
            if (cmd.set && (cmd.channel == chan_idx_t'(ch)))
            begin
                enable_next[ch]  = 1'b0;
                period_next[ch]  = cmd.period;
                compare_next[ch] = cmd.base_count + cmd.period;
            end
            if (cmd.activate && (cmd.channel == chan_idx_t'(ch)))
            begin
                enable_next[ch] = 1'b1;
            end
        end
    end

    assign fire = hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                compare_reg[ch] <= '1;
                period_reg[ch]  <= '1;
            end
        end
        else
        begin
            enable_reg <= enable_next;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                compare_reg[ch] <= compare_next[ch];
                period_reg[ch]  <= period_next[ch];
            end
        end
    end

    // A channel can only fire while it is enabled and the counter steps.
    a_fire_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (fire != '0) |-> (cmd.step && ((fire & ~enable_reg) == '0)))
        else $error("channel fired while disabled or without a counter step");

    // A set-period command to channel 0 leaves that channel disabled.
    a_set_disables: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.set && (cmd.channel == chan_idx_t'(0))) |=> !enable_reg[0])
        else $error("channel 0 still enabled after set-period");

    // When channel 0 fires with no set command, its compare value moves by its period.
    a_fire_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (fire[0] && !cmd.set) |=>
            (compare_reg[0] == count_t'($past(compare_reg[0]) + $past(period_reg[0]))))
        else $error("channel 0 compare did not advance after firing");

endmodule

// ===== hdl/periodic_compare_timer_core.sv =====
// Top level of the periodic compare timer: prescaler, counter and output buffer.
`timescale 1ns / 1ps

// Usage:
// Items enter on the in channel (in_valid/in_ready, fields mode, channel, value):
// a raw clock tick, a set-period command or an activate command for a channel.
// Each accepted item yields exactly one result on the out channel
// (out_valid/out_ready, fields fire_mask and count), registered into the output buffer.
// The block takes one item per cycle while in_ready is high; the prescaler, the
// 16-bit counter step and all seven compares are worked out in the transfer cycle.
// A two-entry output buffer sits before the out channel, so an item is still
// accepted while one result waits; in_ready falls only when both entries are
// full, and nothing is lost or repeated while the receiver stalls.
// The configuration port (cfg_we, cfg_index, cfg_data) sets the input divider
// and the expansion divider; write it only while the block is idle.
// Reset clears the counter, prescaler, enables and dividers, loads all compare
// and period values with all ones and empties the output buffer.
module periodic_compare_timer_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         mode,
    input  pct_pkg::chan_idx_t                 channel,
    input  pct_pkg::count_t                    value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output pct_pkg::chan_mask_t                fire_mask,
    output pct_pkg::count_t                    count,
    input  logic                               cfg_we,
    input  logic [pct_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [pct_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
    import pct_pkg::*;

    logic [LOG2_WIDTH-1:0]     div_log2_reg;
    logic [EXP_WIDTH-1:0]      exp_div_reg;
    logic [PRESCALE_WIDTH-1:0] prescale_reg;
    logic [PRESCALE_WIDTH-1:0] prescale_next;
    count_t                    counter_reg;
    count_t                    counter_next;

    logic                      accept;
    mode_t                     mode_in;
    logic                      in_range;
    logic [DIVISOR_WIDTH-1:0]  divisor;
    logic [DIVISOR_WIDTH-1:0]  prescale_inc;
    logic                      step;
    chan_cmd_t                 cmd;
    chan_mask_t                fire;

    logic       out_valid_reg;
    chan_mask_t out_fire_reg;
    count_t     out_count_reg;
    logic       skid_valid_reg;
    chan_mask_t skid_fire_reg;
    count_t     skid_count_reg;
    logic       pop;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign mode_in  = mode_t'(mode);
    assign in_range = (channel < chan_idx_t'(CHANNELS));

    assign divisor      = DIVISOR_WIDTH'({1'b0, exp_div_reg} + 1'b1) << div_log2_reg;
    assign prescale_inc = DIVISOR_WIDTH'(prescale_reg) + 1'b1;

    always_comb
    begin
        step          = 1'b0;
        prescale_next = prescale_reg;
        counter_next  = counter_reg;
        if (accept && (mode_in == MODE_TICK))
        begin
            if (prescale_inc >= divisor)
            begin
                step          = 1'b1;
                prescale_next = '0;
                counter_next  = counter_reg + 1'b1;
            end
            else
            begin
                prescale_next = prescale_inc[PRESCALE_WIDTH-1:0];
            end
        end
    end

    always_comb
    begin
        cmd.step       = step;
        cmd.set        = accept && (mode_in == MODE_SET) && in_range;
        cmd.activate   = accept && (mode_in == MODE_ACTIVATE) && in_range;
        cmd.channel    = channel;
        cmd.period     = value - 1'b1;
        cmd.base_count = counter_reg;
        cmd.next_count = counter_reg + 1'b1;
    end

    pct_channels u_channels (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .fire  (fire)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_log2_reg <= '0;
            exp_div_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_INPUT_DIVIDER_LOG2: div_log2_reg <= cfg_data[LOG2_WIDTH-1:0];
                REG_EXPANSION_DIVIDER:  exp_div_reg  <= cfg_data[EXP_WIDTH-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            counter_reg  <= '0;
        end
        else
        begin
            prescale_reg <= prescale_next;
            counter_reg  <= counter_next;
        end
    end

    // The skid entry only fills when the head entry is held by a stalled receiver.
    assign pop = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_fire_reg  <= skid_fire_reg;
            out_count_reg <= skid_count_reg;
        end
        else if (accept && (pop || !out_valid_reg))
        begin
            out_fire_reg  <= fire;
            out_count_reg <= counter_next;
        end
        if (accept && out_valid_reg && !pop)
        begin
            skid_fire_reg  <= fire;
            skid_count_reg <= counter_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign fire_mask = out_fire_reg;
    assign count     = out_count_reg;

    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while head entry is empty");

    a_count_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        (counter_reg != $past(counter_reg)) |-> (counter_reg == count_t'($past(counter_reg) + 1'b1)))
        else $error("counter moved by other than one");

    a_fire_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (fire != '0) |-> (accept && (mode_in == MODE_TICK)))
        else $error("fire mask set for an item that is not a tick");

    a_undivided_tick_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode_in == MODE_TICK) && (divisor == DIVISOR_WIDTH'(1)) && !cfg_we)
            |=> (counter_reg == count_t'($past(counter_reg) + 1'b1)))
        else $error("tick with divisor one did not step the counter");

endmodule

// ===== bench/periodic_compare_timer_core_test.sv =====
// Self-checking testbench for the periodic compare timer core.
`timescale 1ns / 1ps

module periodic_compare_timer_core_test;
    import pct_pkg::*;

    typedef struct packed {
        chan_mask_t fire;
        count_t     cnt;
    } timer_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    mode_t      in_mode = MODE_TICK;
    chan_idx_t  in_channel = '0;
    count_t     in_value = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    chan_mask_t out_fire_mask;
    count_t     out_count;
    logic       cfg_we = 1'b0;
    cfg_reg_t   cfg_index = REG_INPUT_DIVIDER_LOG2;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

    // Predicted timer state, kept in step with every transfer on the input side.
    logic [LOG2_WIDTH-1:0]     div_log2 = '0;
    logic [EXP_WIDTH-1:0]      exp_div = '0;
    count_t                    timer_count = '0;
    logic [PRESCALE_WIDTH-1:0] prescale = '0;
    count_t                    compare_at [CHANNELS];
    count_t                    period_of [CHANNELS];
    chan_mask_t                enabled_chans = '0;

    timer_result_t fire_count_queue [$];
    int unsigned   error_count = 0;
    int unsigned   burst_left = 0;
    int unsigned   stall_left = 0;
    int unsigned   stall_style = 0;
    int unsigned   rx_cycles = 0;

    periodic_compare_timer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (in_mode),
        .channel   (in_channel),
        .value     (in_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .fire_mask (out_fire_mask),
        .count     (out_count),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            compare_at[i] = '1;
            period_of[i]  = '1;
        end
    end

    function automatic timer_result_t apply_timer_item(mode_t m, chan_idx_t ch, count_t v);
        timer_result_t r;
        int unsigned   divisor;
        int            i;
        r.fire = '0;
        case (m)
            MODE_TICK:
            begin
                divisor = (1 << div_log2) * (int'(exp_div) + 1);
                if (int'(prescale) + 1 >= divisor)
                begin
                    prescale    = '0;
                    timer_count = timer_count + 1'b1;
                    for (i = 0; i < CHANNELS; i++)
                    begin
                        if (enabled_chans[i] && compare_at[i] == timer_count)
                        begin
                            r.fire[i]     = 1'b1;
                            compare_at[i] = compare_at[i] + period_of[i];
                        end
                    end
                end
                else
                begin
                    prescale = prescale + 1'b1;
                end
            end
            MODE_SET:
            begin
                if (ch < CHANNELS)
                begin
                    enabled_chans[ch] = 1'b0;
                    period_of[ch]     = v - 1'b1;
                    compare_at[ch]    = timer_count + period_of[ch];
                end
            end
            MODE_ACTIVATE:
            begin
                if (ch < CHANNELS)
                    enabled_chans[ch] = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.cnt = timer_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // The sender works in bursts; before a burst, a random gap may drop valid.
    task automatic send_item(input mode_t m, input chan_idx_t ch, input count_t v);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        in_mode    <= m;
        in_channel <= ch;
        in_value   <= v;
        fire_count_queue.push_back(apply_timer_item(m, ch, v));
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Lowers valid in the step of the last transfer, then waits for every result.
    task automatic wait_idle();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (fire_count_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_dividers(input logic [LOG2_WIDTH-1:0] log2_sel,
                                input logic [EXP_WIDTH-1:0] exp_sel);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_INPUT_DIVIDER_LOG2;
        cfg_data  <= CFG_DATA_WIDTH'(log2_sel);
        @(posedge clk);
        cfg_index <= REG_EXPANSION_DIVIDER;
        cfg_data  <= CFG_DATA_WIDTH'(exp_sel);
        @(posedge clk);
        cfg_we   <= 1'b0;
        div_log2 = log2_sel;
        exp_div  = exp_sel;
        @(posedge clk);
    endtask

    function automatic count_t random_period();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return count_t'($urandom_range(0, 20));
        else if (pick < 8)
            return count_t'($urandom_range(0, 300));
        return count_t'($urandom);
    endfunction

    // Results: a transfer with nothing awaited, or any field off, is reported.
    always @(posedge clk)
    begin
        timer_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (fire_count_queue.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result fire_mask=%h count=%h",
                                          out_fire_mask, out_count));
            end
            else
            begin
                want = fire_count_queue.pop_front();
                if (out_fire_mask !== want.fire)
                    report_mismatch($sformatf("fire_mask %h, expected %h (count %h)",
                                              out_fire_mask, want.fire, want.cnt));
                if (out_count !== want.cnt)
                    report_mismatch($sformatf("count %h, expected %h",
                                              out_count, want.cnt));
            end
        end
        rx_cycles++;
        if (rx_cycles % 256 == 0)
            stall_style = $urandom_range(0, 2);
        case (stall_style)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ready <= 1'b0;
                end
                else if ($urandom_range(0, 5) == 0)
                begin
                    stall_left = $urandom_range(0, 7);
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready <= 1'b1;
                end
            end
        endcase
    end

    // Ignored items, channel seven, and the extreme period values.
    task automatic test_directed_cases();
        send_item(MODE_TICK, 3'd5, 16'hffff);
        send_item(MODE_TICK, 3'd0, 16'h0000);
        send_item(MODE_UNUSED, 3'd5, 16'hffff);
        send_item(MODE_SET, 3'd7, 16'd5);
        send_item(MODE_ACTIVATE, 3'd7, 16'd0);
        send_item(MODE_SET, 3'd0, 16'd3);
        send_item(MODE_ACTIVATE, 3'd0, 16'd0);
        send_item(MODE_SET, 3'd6, 16'hffff);
        send_item(MODE_ACTIVATE, 3'd6, 16'd0);
        send_item(MODE_SET, 3'd1, 16'd0);
        send_item(MODE_ACTIVATE, 3'd1, 16'd0);
        send_item(MODE_SET, 3'd4, 16'd2);
        send_item(MODE_ACTIVATE, 3'd4, 16'd0);
        repeat (6) send_item(MODE_TICK, 3'd0, 16'd0);
        // Reprogramming an enabled channel leaves it disabled.
        send_item(MODE_SET, 3'd4, 16'd2);
        send_item(MODE_TICK, 3'd4, 16'd0);
        send_item(MODE_SET, 3'd2, 16'd1);
        send_item(MODE_ACTIVATE, 3'd2, 16'd0);
        send_item(MODE_TICK, 3'd2, 16'd1);
        wait_idle();
    endtask

    // An all-ones period stays silent over a short run of ticks.
    task automatic test_long_period();
        send_item(MODE_SET, 3'd3, 16'd0);
        send_item(MODE_ACTIVATE, 3'd3, 16'd0);
        repeat (40) send_item(MODE_TICK, chan_idx_t'($urandom), count_t'($urandom));
        wait_idle();
    endtask

    task automatic random_items(input int unsigned n);
        chan_idx_t   ch;
        int unsigned pick;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            ch = ($urandom_range(0, 7) == 0) ? chan_idx_t'(7) : chan_idx_t'($urandom_range(0, 6));
            if (pick < 12)
            begin
                send_item(MODE_SET, ch, random_period());
                send_item(MODE_ACTIVATE, ch, count_t'($urandom));
            end
            else if (pick < 75)
                send_item(MODE_TICK, chan_idx_t'($urandom), count_t'($urandom));
            else if (pick < 85)
                send_item(MODE_SET, ch, random_period());
            else if (pick < 95)
                send_item(MODE_ACTIVATE, ch, count_t'($urandom));
            else
                send_item(MODE_UNUSED, chan_idx_t'($urandom), count_t'($urandom));
        end
    endtask

    // Random traffic over several divider settings; the prescaler carries over
    // between them, so a smaller divisor may step the counter on the next tick.
    task automatic test_random_dividers();
        set_dividers(2'd3, 3'd7);
        random_items(200);
        set_dividers(2'd0, 3'd3);
        random_items(250);
        set_dividers(2'd2, 3'd1);
        random_items(250);
        set_dividers(2'd1, 3'd7);
        random_items(200);
        set_dividers(2'd3, 3'd0);
        random_items(250);
        set_dividers(2'd0, 3'd0);
        random_items(400);
        wait_idle();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_long_period();
        test_random_dividers();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
